// File: sv/clns_pkg.sv
`timescale 1ns / 1ps
package clns_pkg;

  localparam int PC_W = 4;
  localparam int CFG_ADDR_W = 5;
  localparam logic [PC_W-1:0] PC_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_BYTE = 4'd12;
  localparam logic [PC_W-1:0] PC_END = 4'd13;

  localparam logic [16:0] POWER_UP_RESET = 17'd50000;
  localparam logic [15:0] WAKE_RESET = 16'd5000;
  localparam logic [7:0] ENABLE_RESET = 8'd5;
  localparam logic [9:0] GAP_RESET = 10'd60;
  localparam logic [15:0] CLEAR_RESET = 16'd2000;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_CHAR = 2'd1,
    ACT_RAW = 2'd2,
    ACT_CURSOR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_POWER_UP = 3'd0,
    REG_WAKE = 3'd1,
    REG_ENABLE = 3'd2,
    REG_GAP = 3'd3,
    REG_CLEAR = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HI = 2'd1,
    NIB_LO = 2'd2
  } nib_sel_t;

  typedef enum logic [1:0] {
    EXTRA_NONE = 2'd0,
    EXTRA_WAKE = 2'd1,
    EXTRA_GAP = 2'd2,
    EXTRA_GAP_CLR = 2'd3
  } extra_sel_t;

  typedef struct packed {
    nib_sel_t nib_sel;
    logic [3:0] nib_const;
    logic rs_from_reg;
    logic before_power_up;
    extra_sel_t extra_sel;
    logic last;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{NIB_CONST, 4'h0, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
    case (pc)
      4'd0: c = '{NIB_CONST, 4'h3, 1'b0, 1'b1, EXTRA_WAKE, 1'b0};
      4'd1: c = '{NIB_CONST, 4'h3, 1'b0, 1'b0, EXTRA_WAKE, 1'b0};
      4'd2: c = '{NIB_CONST, 4'h3, 1'b0, 1'b0, EXTRA_WAKE, 1'b0};
      4'd3: c = '{NIB_CONST, 4'h2, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
      4'd4: c = '{NIB_CONST, 4'h2, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
      4'd5: c = '{NIB_CONST, 4'h8, 1'b0, 1'b0, EXTRA_GAP, 1'b0};
      4'd6: c = '{NIB_CONST, 4'h0, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
      4'd7: c = '{NIB_CONST, 4'hC, 1'b0, 1'b0, EXTRA_GAP, 1'b0};
      4'd8: c = '{NIB_CONST, 4'h0, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
      4'd9: c = '{NIB_CONST, 4'h1, 1'b0, 1'b0, EXTRA_GAP_CLR, 1'b0};
      4'd10: c = '{NIB_CONST, 4'h0, 1'b0, 1'b0, EXTRA_NONE, 1'b0};
      4'd11: c = '{NIB_CONST, 4'h6, 1'b0, 1'b0, EXTRA_GAP, 1'b1};
      4'd12: c = '{NIB_HI, 4'h0, 1'b1, 1'b0, EXTRA_NONE, 1'b0};
      4'd13: c = '{NIB_LO, 4'h0, 1'b1, 1'b0, EXTRA_GAP_CLR, 1'b1};
      default: c = '{NIB_CONST, 4'h0, 1'b0, 1'b0, EXTRA_NONE, 1'b1};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

// File: sv/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps
// A request is taken into busy and the step counter; its first strobe is then registered in the output register.
// One strobe per cycle from the step counter unless the output stalls, one ROM step per strobe;
// init gives 12 strobes per request, all other actions 2 strobes.
// A new request is taken while the last strobe still waits at the output register.
// Reset (synchronous): sequencer idle, output empty, configuration registers back to their default values.
module char_lcd_nibble_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [clns_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic                             is_data,
  input  logic [7:0]                       byte_value,
  input  logic [4:0]                       col,
  input  logic [2:0]                       row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             rs,
  output logic [3:0]                       nibble,
  output logic [16:0]                      wait_before_us,
  output logic [7:0]                       enable_high_us,
  output logic [16:0]                      wait_after_us,
  output logic                             last
);
  import clns_pkg::*;

  logic [16:0] power_up_wait;
  logic [15:0] wake_wait;
  logic [7:0] enable_pulse;
  logic [9:0] byte_gap;
  logic [15:0] clear_wait;

  logic busy;
  logic [PC_W-1:0] pc;
  logic [7:0] byte_reg;
  logic rs_reg;
  logic clr_reg;

  logic cfg_write;
  logic in_take;
  logic advance;
  ctrl_t ctrl;
  logic [7:0] req_byte;
  logic req_rs;
  logic req_clr;
  logic [7:0] cursor_addr;
  logic [3:0] nib_next;
  logic [16:0] extra;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_wait <= POWER_UP_RESET;
      wake_wait <= WAKE_RESET;
      enable_pulse <= ENABLE_RESET;
      byte_gap <= GAP_RESET;
      clear_wait <= CLEAR_RESET;
    end else if (cfg_write) begin
      case (paddr[CFG_ADDR_W-1:2])
        REG_POWER_UP: power_up_wait <= pwdata[16:0];
        REG_WAKE: wake_wait <= pwdata[15:0];
        REG_ENABLE: enable_pulse <= pwdata[7:0];
        REG_GAP: byte_gap <= pwdata[9:0];
        REG_CLEAR: clear_wait <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_POWER_UP: prdata = {15'd0, power_up_wait};
      REG_WAKE: prdata = {16'd0, wake_wait};
      REG_ENABLE: prdata = {24'd0, enable_pulse};
      REG_GAP: prdata = {22'd0, byte_gap};
      REG_CLEAR: prdata = {16'd0, clear_wait};
      default: prdata = 32'd0;
    endcase
  end

  assign in_stall = busy;
  assign in_take = in_valid && !busy;
  assign advance = busy && (!out_valid || !out_stall);
  assign ctrl = ucode(pc);
  assign cursor_addr = row_base(row[1:0] - 2'd1) + {3'd0, col} - 8'd1;

  always_comb begin
    req_byte = byte_value;
    req_rs = 1'b0;
    req_clr = 1'b0;
    case (action_t'(action))
      ACT_INIT: req_clr = 1'b1;
      ACT_CHAR: begin
        if (byte_value == CHAR_FORM_FEED) begin
          req_byte = CMD_CLEAR;
          req_clr = 1'b1;
        end else begin
          req_rs = 1'b1;
        end
      end
      ACT_RAW: req_rs = is_data;
      ACT_CURSOR: req_byte = CMD_SET_DDRAM | cursor_addr;
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl.nib_sel)
      NIB_HI: nib_next = byte_reg[7:4];
      NIB_LO: nib_next = byte_reg[3:0];
      default: nib_next = ctrl.nib_const;
    endcase
    case (ctrl.extra_sel)
      EXTRA_WAKE: extra = {1'b0, wake_wait};
      EXTRA_GAP: extra = {7'd0, byte_gap};
      EXTRA_GAP_CLR: extra = {7'd0, byte_gap} + (clr_reg ? {1'b0, clear_wait} : 17'd0);
      default: extra = 17'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= PC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
        pc <= (action_t'(action) == ACT_INIT) ? PC_INIT : PC_BYTE;
      end else if (advance) begin
        pc <= pc + 1'b1;
        if (ctrl.last) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_reg <= req_byte;
      rs_reg <= req_rs;
      clr_reg <= req_clr;
    end
    if (advance) begin
      rs <= ctrl.rs_from_reg ? rs_reg : 1'b0;
      nibble <= nib_next;
      wait_before_us <= ctrl.before_power_up ? power_up_wait : 17'd0;
      enable_high_us <= enable_pulse;
      wait_after_us <= {9'd0, enable_pulse} + extra;
      last <= ctrl.last;
    end
  end

`ifndef SYNTH
  a_take_busy: assert property (@(posedge clk) disable iff (rst) in_take |=> busy)
    else $error("request transaction did not start the sequencer");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.last |=> !busy && out_valid && last)
    else $error("final step did not end the request");
  a_pc_range: assert property (@(posedge clk) disable iff (rst) busy |-> pc <= PC_END)
    else $error("step counter ran past the program");
  a_step_out: assert property (@(posedge clk) disable iff (rst) advance |=> out_valid)
    else $error("step did not produce a strobe");
`endif

endmodule

// File: tb/sv/char_lcd_nibble_sequencer_tb.sv
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_tb;
  import clns_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_REGS = 5;
  localparam int LONG_HOLD = 300;
  localparam int PRINT_CAP = 40;
  localparam int DIR_ROWS = 22;

  localparam logic RS_CMD = 1'b0;
  localparam logic RS_DATA = 1'b1;
  localparam logic [3:0] WAKE_NIBBLE = 4'h3;
  localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

  typedef struct packed {
    action_t act;
    logic is_data;
    logic [7:0] byte_value;
    logic [4:0] col;
    logic [2:0] row;
  } lcd_req_t;

  typedef struct packed {
    lcd_req_t req;
    logic typed;
    logic exp_rs;
    logic [7:0] exp_byte;
    logic exp_clear;
  } dir_row_t;

  typedef struct packed {
    logic rs;
    logic [3:0] nib;
    logic [16:0] lead;
    logic [7:0] en_high;
    logic [16:0] after;
    logic last;
  } strobe_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic [1:0] action;
  logic is_data;
  logic [7:0] byte_value;
  logic [4:0] col;
  logic [2:0] row;
  logic out_valid;
  logic out_stall;
  logic rs;
  logic [3:0] nibble;
  logic [16:0] wait_before_us;
  logic [7:0] enable_high_us;
  logic [16:0] wait_after_us;
  logic last;

  logic [16:0] cfg_power_up;
  logic [15:0] cfg_wake;
  logic [7:0] cfg_enable;
  logic [9:0] cfg_gap;
  logic [15:0] cfg_clear;

  logic [7:0] cursor_base [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  strobe_t expected_strobes [$];
  dir_row_t dir_table [DIR_ROWS];

  bit idling;
  bit hold_req;
  int cycles;
  int n_errors;
  int n_requests;
  int n_strobes;
  int n_settings;

  char_lcd_nibble_sequencer u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .is_data(is_data),
    .byte_value(byte_value),
    .col(col),
    .row(row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rs(rs),
    .nibble(nibble),
    .wait_before_us(wait_before_us),
    .enable_high_us(enable_high_us),
    .wait_after_us(wait_after_us),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("char_lcd_nibble_sequencer_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < PRINT_CAP) begin
      $display("mismatch %0s: got 0x%0h expected 0x%0h (cycle %0d)", what, got, want, cycles);
    end
    n_errors++;
  endtask

  task automatic add_strobe(input logic rs_l, input logic [3:0] nib, input logic [16:0] lead,
                            input logic [31:0] extra, input logic is_last);
    strobe_t s;
    s.rs = rs_l;
    s.nib = nib;
    s.lead = lead;
    s.en_high = cfg_enable;
    s.after = 17'(32'(cfg_enable) + extra);
    s.last = is_last;
    expected_strobes.push_back(s);
  endtask

  task automatic add_byte(input logic rs_l, input logic [7:0] b, input logic [31:0] extra,
                          input logic is_last);
    add_strobe(rs_l, b[7:4], 17'd0, 32'd0, 1'b0);
    add_strobe(rs_l, b[3:0], 17'd0, 32'(cfg_gap) + extra, is_last);
  endtask

  task automatic predict_strobes(input lcd_req_t r);
    logic [7:0] addr;
    case (r.act)
      ACT_INIT: begin
        add_strobe(RS_CMD, WAKE_NIBBLE, cfg_power_up, 32'(cfg_wake), 1'b0);
        add_strobe(RS_CMD, WAKE_NIBBLE, 17'd0, 32'(cfg_wake), 1'b0);
        add_strobe(RS_CMD, WAKE_NIBBLE, 17'd0, 32'(cfg_wake), 1'b0);
        add_strobe(RS_CMD, BUS_4BIT_NIBBLE, 17'd0, 32'd0, 1'b0);
        add_byte(RS_CMD, CMD_FUNCTION_SET, 32'd0, 1'b0);
        add_byte(RS_CMD, CMD_DISPLAY_ON, 32'd0, 1'b0);
        add_byte(RS_CMD, CMD_CLEAR, 32'(cfg_clear), 1'b0);
        add_byte(RS_CMD, CMD_ENTRY_MODE, 32'd0, 1'b1);
      end
      ACT_CHAR: begin
        if (r.byte_value == CHAR_FORM_FEED) begin
          add_byte(RS_CMD, CMD_CLEAR, 32'(cfg_clear), 1'b1);
        end else begin
          add_byte(RS_DATA, r.byte_value, 32'd0, 1'b1);
        end
      end
      ACT_RAW: begin
        add_byte(r.is_data, r.byte_value, 32'd0, 1'b1);
      end
      default: begin
        addr = 8'(cursor_base[2'(r.row - 3'd1)] + {3'b000, r.col} - 8'd1);
        add_byte(RS_CMD, CMD_SET_DDRAM | addr, 32'd0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : check_strobes
    strobe_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_strobes.size() == 0) begin
        report_mismatch("strobe with none pending, nibble", 32'(nibble), 32'd0);
      end else begin
        want = expected_strobes.pop_front();
        n_strobes++;
        if (rs !== want.rs) report_mismatch("rs", 32'(rs), 32'(want.rs));
        if (nibble !== want.nib) report_mismatch("nibble", 32'(nibble), 32'(want.nib));
        if (wait_before_us !== want.lead) begin
          report_mismatch("wait_before_us", 32'(wait_before_us), 32'(want.lead));
        end
        if (enable_high_us !== want.en_high) begin
          report_mismatch("enable_high_us", 32'(enable_high_us), 32'(want.en_high));
        end
        if (wait_after_us !== want.after) begin
          report_mismatch("wait_after_us", 32'(wait_after_us), 32'(want.after));
        end
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  initial begin : receiver
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input int idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx * 4);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_POWER_UP: cfg_power_up = data[16:0];
      REG_WAKE: cfg_wake = data[15:0];
      REG_ENABLE: cfg_enable = data[7:0];
      REG_GAP: cfg_gap = data[9:0];
      REG_CLEAR: cfg_clear = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_readback();
    logic [31:0] want;
    int k;
    for (k = 0; k < NUM_REGS; k++) begin
      case (k)
        REG_POWER_UP: want = 32'(cfg_power_up);
        REG_WAKE: want = 32'(cfg_wake);
        REG_ENABLE: want = 32'(cfg_enable);
        REG_GAP: want = 32'(cfg_gap);
        default: want = 32'(cfg_clear);
      endcase
      @(negedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CFG_ADDR_W'(k * 4);
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== want) report_mismatch($sformatf("readback reg %0d", k), prdata, want);
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
    n_settings++;
  endtask

  task automatic cfg_random();
    cfg_write(REG_POWER_UP, $urandom());
    cfg_write(REG_WAKE, $urandom());
    cfg_write(REG_ENABLE, $urandom());
    cfg_write(REG_GAP, $urandom());
    cfg_write(REG_CLEAR, $urandom());
    check_readback();
  endtask

  task automatic drive_request(input lcd_req_t r);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= r.act;
    is_data <= r.is_data;
    byte_value <= r.byte_value;
    col <= r.col;
    row <= r.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_requests++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_strobes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int n, input int pause_at);
    lcd_req_t r;
    int pick;
    int i;
    for (i = 0; i < n; i++) begin
      if (i == pause_at) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_strobes.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) r.act = ACT_INIT;
      else if (pick < 40) r.act = ACT_CHAR;
      else if (pick < 65) r.act = ACT_RAW;
      else r.act = ACT_CURSOR;
      r.is_data = 1'($urandom());
      r.byte_value = ($urandom_range(0, 7) == 0) ? CHAR_FORM_FEED : 8'($urandom());
      r.col = ($urandom_range(0, 6) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 20));
      r.row = ($urandom_range(0, 6) == 0) ? 3'($urandom()) : 3'($urandom_range(1, 4));
      drive_request(r);
      predict_strobes(r);
    end
  endtask

  initial begin : stimulus
    int i;
    int k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    action = ACT_INIT;
    is_data = 1'b0;
    byte_value = 8'h00;
    col = 5'd1;
    row = 3'd1;
    idling = 1'b0;
    hold_req = 1'b0;
    cycles = 0;
    n_errors = 0;
    n_requests = 0;
    n_strobes = 0;
    n_settings = 0;
    cfg_power_up = POWER_UP_RESET;
    cfg_wake = WAKE_RESET;
    cfg_enable = ENABLE_RESET;
    cfg_gap = GAP_RESET;
    cfg_clear = CLEAR_RESET;

    dir_table = '{
      '{'{ACT_INIT, 1'b0, 8'h00, 5'd1, 3'd1}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_CHAR, 1'b0, 8'h41, 5'd1, 3'd1}, 1'b1, RS_DATA, 8'h41, 1'b0},
      '{'{ACT_CHAR, 1'b1, 8'h0C, 5'd1, 3'd1}, 1'b1, RS_CMD, 8'h01, 1'b1},
      '{'{ACT_CHAR, 1'b0, 8'h00, 5'd1, 3'd1}, 1'b1, RS_DATA, 8'h00, 1'b0},
      '{'{ACT_CHAR, 1'b1, 8'hFF, 5'd1, 3'd1}, 1'b1, RS_DATA, 8'hFF, 1'b0},
      '{'{ACT_CHAR, 1'b0, 8'h0B, 5'd1, 3'd1}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_CHAR, 1'b0, 8'h0D, 5'd1, 3'd1}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_RAW, 1'b0, 8'h00, 5'd1, 3'd1}, 1'b1, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_RAW, 1'b1, 8'hFF, 5'd1, 3'd1}, 1'b1, RS_DATA, 8'hFF, 1'b0},
      '{'{ACT_RAW, 1'b0, 8'h0C, 5'd1, 3'd1}, 1'b1, RS_CMD, 8'h0C, 1'b0},
      '{'{ACT_RAW, 1'b1, 8'h5A, 5'd1, 3'd1}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_RAW, 1'b0, 8'h01, 5'd1, 3'd1}, 1'b1, RS_CMD, 8'h01, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h00, 5'd1, 3'd1}, 1'b1, RS_CMD, 8'h80, 1'b0},
      '{'{ACT_CURSOR, 1'b1, 8'hFF, 5'd1, 3'd2}, 1'b1, RS_CMD, 8'hC0, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h00, 5'd20, 3'd3}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h0C, 5'd20, 3'd4}, 1'b1, RS_CMD, 8'hE7, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h00, 5'd1, 3'd0}, 1'b1, RS_CMD, 8'hD4, 1'b0},
      '{'{ACT_CURSOR, 1'b1, 8'h00, 5'd1, 3'd5}, 1'b1, RS_CMD, 8'h80, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'hFF, 5'd31, 3'd7}, 1'b0, RS_CMD, 8'h00, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h00, 5'd0, 3'd1}, 1'b1, RS_CMD, 8'hFF, 1'b0},
      '{'{ACT_CURSOR, 1'b0, 8'h00, 5'd0, 3'd2}, 1'b1, RS_CMD, 8'hBF, 1'b0},
      '{'{ACT_INIT, 1'b1, 8'hFF, 5'd31, 3'd7}, 1'b0, RS_CMD, 8'h00, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_readback();
    idling = 1'b1;
    for (i = 0; i < DIR_ROWS; i++) begin
      drive_request(dir_table[i].req);
      if (dir_table[i].typed) begin
        add_byte(dir_table[i].exp_rs, dir_table[i].exp_byte,
                 dir_table[i].exp_clear ? 32'(cfg_clear) : 32'd0, 1'b1);
      end else begin
        predict_strobes(dir_table[i].req);
      end
    end
    settle();

    // all registers at full scale, then writes past the register list
    cfg_write(REG_POWER_UP, 32'hFFFF_FFFF);
    cfg_write(REG_WAKE, 32'hFFFF_FFFF);
    cfg_write(REG_ENABLE, 32'hFFFF_FFFF);
    cfg_write(REG_GAP, 32'hFFFF_FFFF);
    cfg_write(REG_CLEAR, 32'hFFFF_FFFF);
    for (k = NUM_REGS; k < 8; k++) cfg_write(k, $urandom());
    check_readback();
    hold_req = 1'b1;
    run_random(70, -1);
    settle();

    cfg_write(REG_POWER_UP, 32'd0);
    cfg_write(REG_WAKE, 32'd0);
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_GAP, 32'd0);
    cfg_write(REG_CLEAR, 32'd0);
    check_readback();
    run_random(70, 35);
    settle();

    repeat (2) begin
      cfg_random();
      run_random(70, -1);
      settle();
    end

    idling = 1'b0;
    cfg_random();
    run_random(80, -1);
    settle();
    repeat (20) @(posedge clk);

    if (expected_strobes.size() != 0) begin
      report_mismatch("strobes still pending", 32'(expected_strobes.size()), 32'd0);
    end
    $display("run covered %0d requests (init, characters, form feed, raw bytes, cursor wrap)",
             n_requests);
    $display("and checked %0d strobes over %0d register settings", n_strobes, n_settings);
    if (n_errors == 0) begin
      $display("char_lcd_nibble_sequencer_tb: clean");
    end else begin
      $display("char_lcd_nibble_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
